>>> sv/fpsa_pkg.sv
// Package for the feedback packet spacing adjuster: codes, request types and defaults.
package fpsa_pkg;

  // Default fixed-point format of the running spacing (Q24.16).
  localparam int FracBitsDef = 16;
  localparam int IntBitsDef  = 24;

  // Field widths of the external requests and the configuration port.
  localparam int SpacingW = 40;
  localparam int QueueW   = 32;
  localparam int RateW    = 32;
  localparam int CfgDataW = 40;
  localparam int CfgIdxW  = 1;
  localparam int ModeW    = 3;

  // Feedback message kinds.
  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActSlow   = 2'd1,
    ActFast   = 2'd2,
    ActIgnore = 2'd3
  } action_e;

  // Adjustment rules; the codes above ModeHold behave like hold.
  typedef enum logic [ModeW-1:0] {
    ModeLinear = 3'd0,
    ModeMult   = 3'd1,
    ModeDiff   = 3'd2,
    ModeTau    = 3'd3,
    ModeHold   = 3'd4
  } adjust_mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgAdjustMode   = 1'b0,
    CfgStartSpacing = 1'b1
  } cfg_idx_e;

  // Incoming feedback request.
  typedef struct packed {
    action_e                   action;
    logic signed [QueueW-1:0]  queue_difference;
    logic signed [RateW-1:0]   client_rate;
  } req_in_t;

  // Outgoing result request.
  typedef struct packed {
    logic [SpacingW-1:0] spacing_out;
    logic                clear_seen;
  } req_out_t;

endpackage

>>> sv/fpsa_update.sv
// Combinational next-spacing computation for one feedback request.
module fpsa_update #(
  parameter int FRAC_BITS = fpsa_pkg::FracBitsDef,
  parameter int INT_BITS  = fpsa_pkg::IntBitsDef
) (
  input  logic [INT_BITS+FRAC_BITS-1:0] spacing_i,
  input  fpsa_pkg::adjust_mode_e        mode_i,
  input  fpsa_pkg::req_in_t             req_i,
  output logic [INT_BITS+FRAC_BITS-1:0] spacing_o
);
  import fpsa_pkg::*;

  localparam int W      = INT_BITS + FRAC_BITS;
  localparam int KW     = FRAC_BITS + 2;
  localparam int TauW   = ((W > RateW - 1 + FRAC_BITS) ? W : RateW - 1 + FRAC_BITS) + 2;
  localparam int TauHiW = TauW - FRAC_BITS;
  localparam int PrdW   = QueueW + KW;
  localparam int SumA   = (W + 1 > PrdW) ? W + 1 : PrdW;
  localparam int SumW   = ((SumA > TauW) ? SumA : TauW) + 2;
  localparam int LoW    = FRAC_BITS + KW;
  localparam int K11HiW = INT_BITS + KW;
  localparam int TauPW  = TauHiW + KW;

  // Coefficients rounded to nearest at the fraction point.
  localparam logic [KW-1:0] K11   = KW'((11 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic [KW-1:0] K15   = KW'((3 * (1 << FRAC_BITS)) / 2);
  localparam logic [KW-1:0] K1m   = KW'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [KW-1:0] K100u = KW'(((1 << FRAC_BITS) + 5000) / 10000);
  localparam logic [KW-1:0] K15m  = KW'((15 * (1 << FRAC_BITS) + 500) / 1000);

  localparam logic [LoW-1:0]         HalfLo = LoW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SumW-1:0] OneS   = SumW'(1) << FRAC_BITS;
  localparam logic signed [SumW-1:0] MaxS   = SumW'({W{1'b1}});

  logic [QueueW-1:0]       abs_d;
  logic [PrdW-1:0]         small_p;
  logic [PrdW-1:0]         diff_p;
  logic [K11HiW-1:0]       k11_hi;
  logic [LoW-1:0]          k11_lo;
  logic [SumW-1:0]         k11_prod;
  logic signed [TauW-1:0]  tau;
  logic                    tau_neg;
  logic [TauW-1:0]         tau_mag;
  logic [TauPW-1:0]        tau_hi;
  logic [LoW-1:0]          tau_lo;
  logic [SumW-1:0]         tau_prod;
  logic signed [SumW-1:0]  tau_term;
  logic signed [SumW-1:0]  s_ext;
  logic signed [SumW-1:0]  small_s;
  logic signed [SumW-1:0]  sum;

  // Magnitude of the queue difference; the most negative code maps to 2^31.
  assign abs_d = req_i.queue_difference[QueueW-1] ? QueueW'(-req_i.queue_difference)
                                                  : QueueW'(req_i.queue_difference);
  assign small_p = PrdW'(abs_d) * PrdW'(K100u);
  assign diff_p  = PrdW'(abs_d) * PrdW'(K1m);

  // Spacing times 1.1, rounded half up, split into integer and fraction parts.
  assign k11_hi   = K11HiW'(spacing_i[W-1:FRAC_BITS]) * K11HiW'(K11);
  assign k11_lo   = LoW'(spacing_i[FRAC_BITS-1:0]) * LoW'(K11) + HalfLo;
  assign k11_prod = SumW'(k11_hi) + SumW'(k11_lo >> FRAC_BITS);

  // Tau is the spacing minus the scaled client rate.
  assign tau     = $signed(TauW'(spacing_i))
                 - ($signed(TauW'($signed(req_i.client_rate))) <<< FRAC_BITS);
  assign tau_neg = tau[TauW-1];
  assign tau_mag = tau_neg ? TauW'(-tau) : TauW'(tau);

  // Tau times 0.015 on its magnitude, rounded half away from zero.
  assign tau_hi   = TauPW'(tau_mag[TauW-1:FRAC_BITS]) * TauPW'(K15m);
  assign tau_lo   = LoW'(tau_mag[FRAC_BITS-1:0]) * LoW'(K15m) + HalfLo;
  assign tau_prod = SumW'(tau_hi) + SumW'(tau_lo >> FRAC_BITS);
  assign tau_term = tau_neg ? -$signed(tau_prod) : $signed(tau_prod);

  assign s_ext   = $signed(SumW'(spacing_i));
  assign small_s = $signed(SumW'(small_p));

  // Rule selection by message kind and mode.
  always_comb begin
    sum = s_ext;
    case (req_i.action)
      ActSlow: begin
        case (mode_i)
          ModeLinear: sum = s_ext + OneS;
          ModeMult:   sum = $signed(k11_prod);
          ModeDiff:   sum = s_ext + $signed(SumW'(diff_p));
          ModeTau:    sum = s_ext + small_s - tau_term;
          default:    sum = s_ext;
        endcase
      end
      ActFast: begin
        case (mode_i)
          ModeLinear: sum = s_ext - OneS;
          ModeMult:   sum = s_ext - $signed(SumW'(K15));
          ModeDiff:   sum = s_ext - small_s;
          ModeTau:    sum = s_ext - small_s + tau_term;
          default:    sum = s_ext;
        endcase
      end
      default: sum = s_ext;
    endcase
  end

  // Range check: non-positive becomes 1.0, overflow saturates.
  always_comb begin
    if (sum <= 0) begin
      spacing_o = W'(OneS);
    end else if (sum > MaxS) begin
      spacing_o = {W{1'b1}};
    end else begin
      spacing_o = sum[W-1:0];
    end
  end

endmodule

>>> sv/feedback_packet_spacing_adjuster_core.sv
// Top level of the feedback packet spacing adjuster: request pipeline, state and configuration.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+----------------------------
//  in       | input     | in_valid_i / in_ready_o      | in_req_i (req_in_t)
//  out      | output    | out_valid_o / out_ready_i    | out_req_o (req_out_t)
//  cfg      | input     | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// A request accepted into the input register passes through the spacing update, a single
// pass of constant multiplies and adds, into the result register once that register is free
// or being taken; the result then waits in the result register until it is taken.
// A new request can be accepted every cycle while the result side is not stalled.
// Reset loads the spacing with 1.0, clears the clear flag and selects the linear rule.
// A stalled result holds the pipeline; the input register still takes a request while
// the result register is waiting to be taken, as long as the input register is empty.
module feedback_packet_spacing_adjuster_core #(
  parameter int FRAC_BITS = fpsa_pkg::FracBitsDef,
  parameter int INT_BITS  = fpsa_pkg::IntBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fpsa_pkg::req_in_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fpsa_pkg::req_out_t            out_req_o,
  input  logic                          cfg_we_i,
  input  logic [fpsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fpsa_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import fpsa_pkg::*;

  localparam int W    = INT_BITS + FRAC_BITS;
  localparam int ExtW = (W > SpacingW) ? W : SpacingW;
  localparam logic [W-1:0] OneQ = W'(1) << FRAC_BITS;

  logic         in_valid_q;
  req_in_t      in_q;
  logic         out_valid_q;
  req_out_t     out_q;
  logic [W-1:0] spacing_q;
  logic [W-1:0] spacing_d;
  logic         clear_q;
  logic         clear_d;
  adjust_mode_e mode_q;
  logic         advance;
  logic         in_accept;
  logic [ExtW-1:0] cfg_ext;
  logic [ExtW-1:0] spc_ext;

  // Pipeline control.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Next state from the request in the input register.
  fpsa_update #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
  ) u_update (
    .spacing_i(spacing_q),
    .mode_i   (mode_q),
    .req_i    (in_q),
    .spacing_o(spacing_d)
  );

  assign clear_d = clear_q || (in_q.action == ActClear);

  // Width adaptation between the spacing and the 40-bit fields.
  assign cfg_ext = ExtW'(cfg_wdata_i);
  assign spc_ext = ExtW'(spacing_d);

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.spacing_out <= spc_ext[SpacingW-1:0];
      out_q.clear_seen  <= clear_d;
    end
  end

  // Running spacing, clear flag and mode; configuration writes take priority.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= OneQ;
      clear_q   <= 1'b0;
      mode_q    <= ModeLinear;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgAdjustMode:   mode_q    <= adjust_mode_e'(cfg_wdata_i[ModeW-1:0]);
        CfgStartSpacing: spacing_q <= cfg_ext[W-1:0];
        default:         mode_q    <= mode_q;
      endcase
    end else if (advance) begin
      spacing_q <= spacing_d;
      clear_q   <= clear_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the feedback packet spacing adjuster core.
module tb_top;
  import fpsa_pkg::*;

  // Fixed-point format and rounded coefficients of the spacing update.
  localparam int     FracBits = FracBitsDef;
  localparam longint OneQ     = longint'(1) << FracBits;
  localparam longint SpcMax   = (longint'(1) << (IntBitsDef + FracBits)) - 1;
  localparam longint K11      = (11 * OneQ + 5) / 10;
  localparam longint K15      = (3 * OneQ) >> 1;
  localparam longint K1m      = (OneQ + 500) / 1000;
  localparam longint K100u    = (OneQ + 5000) / 10000;
  localparam longint K15m     = (15 * OneQ + 500) / 1000;

  // Mode code above hold that the block must treat as hold.
  localparam logic [ModeW-1:0] ModeTopCode = 3'd7;

  // Field extremes of the signed request fields.
  localparam logic [QueueW-1:0] FieldMin = 32'h8000_0000;
  localparam logic [QueueW-1:0] FieldMax = 32'h7fff_ffff;

  localparam int ClkPeriod     = 12;
  localparam int IdlePct       = 19;
  localparam int PhaseCount    = 9;
  localparam int PhaseRequests = 50;
  localparam int DrainLimit    = 2000;
  localparam int TimeoutCycles = 200000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  req_in_t             in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  req_out_t            out_req_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Shadow copy of the block's registers and state.
  logic [ModeW-1:0]    model_mode    = ModeLinear;
  logic [SpacingW-1:0] model_spacing = SpacingW'(OneQ);
  logic                model_clear   = 1'b0;

  // Spacing updates predicted but not yet delivered, oldest first.
  req_out_t expected_spacing_q[$];

  bit burst_on        = 1'b0;
  int mismatches      = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int reg_writes      = 0;

  feedback_packet_spacing_adjuster_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Timeout after %0d cycles", TimeoutCycles);
    $display("Mismatches found");
    $finish;
  end

  // Nonnegative magnitude times a coefficient, rounded half up at the binary point.
  function automatic longint scale_mag(longint mag, longint coef);
    return (mag >> FracBits) * coef + (((mag & (OneQ - 1)) * coef + (OneQ >> 1)) >> FracBits);
  endfunction

  // Signed value times a coefficient, rounded half away from zero.
  function automatic longint scale_signed(longint v, longint coef);
    if (v < 0) return -scale_mag(-v, coef);
    return scale_mag(v, coef);
  endfunction

  // Applies one feedback request to the shadow state and returns the expected result.
  function automatic req_out_t advance_spacing(req_in_t r);
    longint   s;
    longint   qdiff;
    longint   gamma;
    longint   absd;
    longint   tau;
    longint   fine_step;
    req_out_t res;
    qdiff     = longint'($signed(r.queue_difference));
    gamma     = longint'($signed(r.client_rate));
    absd      = (qdiff < 0) ? -qdiff : qdiff;
    s         = longint'(model_spacing);
    tau       = s - gamma * OneQ;
    fine_step = absd * K100u;
    case (r.action)
      ActClear: model_clear = 1'b1;
      ActSlow: begin
        case (model_mode)
          ModeLinear: s = s + OneQ;
          ModeMult:   s = scale_mag(s, K11);
          ModeDiff:   s = s + absd * K1m;
          ModeTau:    s = s + fine_step - scale_signed(tau, K15m);
          default:    ;
        endcase
      end
      ActFast: begin
        case (model_mode)
          ModeLinear: s = s - OneQ;
          ModeMult:   s = s - K15;
          ModeDiff:   s = s - fine_step;
          ModeTau:    s = s - fine_step + scale_signed(tau, K15m);
          default:    ;
        endcase
      end
      default: ;
    endcase
    // The spacing never drops to zero or below and saturates at the top code.
    if (s <= 0) s = OneQ;
    if (s > SpcMax) s = SpcMax;
    model_spacing   = s[SpacingW-1:0];
    res.spacing_out = model_spacing;
    res.clear_seen  = model_clear;
    return res;
  endfunction

  function automatic void note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s at %0t: expected 0x%0h, got 0x%0h", what, $time, want, got);
    end
  endfunction

  function automatic req_in_t feedback(action_e act, logic [QueueW-1:0] qdiff,
                                       logic [RateW-1:0] gamma);
    req_in_t r;
    r.action           = act;
    r.queue_difference = qdiff;
    r.client_rate      = gamma;
    return r;
  endfunction

  // Random request: mostly slow-down and speed-up, with rates near the spacing at times.
  function automatic req_in_t random_feedback();
    action_e          act;
    logic [QueueW-1:0] qdiff;
    logic [RateW-1:0]  gamma;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 6) act = ActClear;
    else if (pick < 50) act = ActSlow;
    else if (pick < 92) act = ActFast;
    else act = ActIgnore;
    case ($urandom_range(3))
      0: qdiff = $urandom;
      1: qdiff = $urandom_range(2000) - 1000;
      2: qdiff = $urandom_range(1) ? FieldMin : FieldMax;
      default: begin
        qdiff = $urandom_range(1 << 20);
        if ($urandom_range(1)) qdiff = -qdiff;
      end
    endcase
    case ($urandom_range(3))
      0: gamma = $urandom;
      1: gamma = RateW'(model_spacing >> FracBits) + RateW'($urandom_range(20)) - 32'd10;
      2: gamma = $urandom_range(1) ? FieldMin : FieldMax;
      default: gamma = $urandom_range(200) - 100;
    endcase
    return feedback(act, qdiff, gamma);
  endfunction

  // Sends one request; valid stays up after acceptance unless the next call idles.
  task automatic send_feedback(req_in_t r);
    while (!burst_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_spacing_q.push_back(advance_spacing(r));
    requests_sent++;
  endtask

  // Waits until every predicted result has been delivered and the pipeline is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_spacing_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgAdjustMode:   model_mode    = data[ModeW-1:0];
      CfgStartSpacing: model_spacing = data[SpacingW-1:0];
      default:         ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // Reset state: linear rule, spacing 1.0, flag clear; the floor at 1.0 from below.
  task automatic test_after_reset();
    send_feedback(feedback(ActIgnore, FieldMin, FieldMax));
    send_feedback(feedback(ActIgnore, FieldMax, FieldMin));
    send_feedback(feedback(ActFast, '0, '0));
    send_feedback(feedback(ActSlow, '0, '0));
    send_feedback(feedback(ActClear, 32'hffff_ffff, 32'h0000_0001));
  endtask

  // Saturation at the top code under the linear and multiplicative rules.
  task automatic test_saturation();
    write_reg(CfgStartSpacing, CfgDataW'(SpcMax));
    send_feedback(feedback(ActSlow, FieldMax, '0));
    write_reg(CfgAdjustMode, CfgDataW'(ModeMult));
    send_feedback(feedback(ActSlow, '0, FieldMin));
    send_feedback(feedback(ActFast, FieldMin, '0));
  endtask

  // Multiplicative rule from the smallest spacing, including the floor.
  task automatic test_mult_rule();
    write_reg(CfgStartSpacing, CfgDataW'(1));
    send_feedback(feedback(ActSlow, '0, '0));
    send_feedback(feedback(ActFast, '0, '0));
    send_feedback(feedback(ActSlow, 32'h0000_0005, 32'hffff_fffb));
  endtask

  // Difference-scaled rule with the queue difference at both extremes and zero.
  task automatic test_diff_rule();
    write_reg(CfgAdjustMode, CfgDataW'(ModeDiff));
    write_reg(CfgStartSpacing, CfgDataW'(1000 * OneQ));
    send_feedback(feedback(ActSlow, FieldMin, '0));
    send_feedback(feedback(ActFast, FieldMax, '0));
    send_feedback(feedback(ActFast, '0, FieldMax));
    send_feedback(feedback(ActSlow, 32'hffff_fc18, '0));
  endtask

  // Tau rule: tau of both signs and both magnitudes, with saturation and floor.
  task automatic test_tau_rule();
    write_reg(CfgAdjustMode, CfgDataW'(ModeTau));
    write_reg(CfgStartSpacing, CfgDataW'(100 * OneQ));
    send_feedback(feedback(ActSlow, FieldMin, FieldMax));
    send_feedback(feedback(ActSlow, FieldMax, FieldMin));
    send_feedback(feedback(ActFast, '0, FieldMin));
    send_feedback(feedback(ActFast, 32'h0000_1234, FieldMax));
    write_reg(CfgStartSpacing, CfgDataW'(100 * OneQ + 3));
    send_feedback(feedback(ActFast, 32'hffff_f000, 32'd90));
    send_feedback(feedback(ActSlow, 32'h0000_0777, 32'd110));
  endtask

  // Hold and the codes above it leave the spacing alone.
  task automatic test_hold_modes();
    write_reg(CfgAdjustMode, CfgDataW'(ModeHold));
    send_feedback(feedback(ActSlow, FieldMax, FieldMin));
    send_feedback(feedback(ActFast, FieldMin, FieldMax));
    write_reg(CfgAdjustMode, CfgDataW'(ModeTopCode));
    send_feedback(feedback(ActSlow, 32'h0000_4000, 32'h0000_0001));
    send_feedback(feedback(ActFast, 32'hffff_8000, 32'hffff_ffff));
  endtask

  // Random phases over every rule and a spread of start spacings; one phase runs flat out.
  task automatic test_random_phases();
    for (int ph = 0; ph < PhaseCount; ph++) begin
      write_reg(CfgAdjustMode, (ph <= ModeHold) ? CfgDataW'(ph) : CfgDataW'($urandom_range(7)));
      case ($urandom_range(3))
        0: write_reg(CfgStartSpacing, CfgDataW'($urandom_range(1, 64) * OneQ));
        1: write_reg(CfgStartSpacing, CfgDataW'($urandom_range(1, 1 << 30)));
        2: write_reg(CfgStartSpacing, $urandom_range(1) ? CfgDataW'(SpcMax) : CfgDataW'(1));
        default: write_reg(CfgStartSpacing, {8'($urandom_range(1, 255)), 32'($urandom)});
      endcase
      burst_on = (ph == PhaseCount / 2);
      repeat (PhaseRequests) send_feedback(random_feedback());
    end
    burst_on = 1'b0;
  endtask

  // Result side stalls at random except during the flat-out phase.
  always @(posedge clk_i) begin
    out_ready_i <= burst_on || ($urandom_range(99) >= IdlePct);
  end

  // Compare each delivered result with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    req_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_spacing_q.size() == 0) begin
        note_mismatch("unexpected result", 0, longint'(out_req_o.spacing_out));
      end else begin
        want = expected_spacing_q.pop_front();
        if (out_req_o.spacing_out !== want.spacing_out) begin
          note_mismatch("spacing_out", longint'(want.spacing_out),
                        longint'(out_req_o.spacing_out));
        end
        if (out_req_o.clear_seen !== want.clear_seen) begin
          note_mismatch("clear_seen", longint'(want.clear_seen),
                        longint'(out_req_o.clear_seen));
        end
        results_checked++;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_saturation();
    test_mult_rule();
    test_diff_rule();
    test_tau_rule();
    test_hold_modes();
    test_random_phases();

    // Drain with a bound, then let the pipeline run empty.
    in_valid_i <= 1'b0;
    for (int n = 0; n < DrainLimit && expected_spacing_q.size() != 0; n++) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (expected_spacing_q.size() != 0) begin
      $display("%0d predicted results never arrived", expected_spacing_q.size());
      mismatches += expected_spacing_q.size();
    end

    $display("Sent %0d feedback requests, checked %0d results, made %0d register writes.",
             requests_sent, results_checked, reg_writes);
    $display("Covered all rules and undefined mode codes, saturation and the 1.0 floor.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
